>>> sv/lsqws_pkg.sv
// Shared constants and types for the load/store wakeup-select buffer.
package lsqws_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned RobTags    = 32;
  localparam int unsigned TagW       = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AccW       = 8;
  localparam int unsigned OffW       = 12;

  localparam logic [1:0] KindCycle   = 2'd0;
  localparam logic [1:0] KindEnqueue = 2'd1;
  localparam logic [1:0] KindFlush   = 2'd2;
  localparam logic [1:0] KindUnused  = 2'd3;

  // Command from controller to datapath.
  typedef struct packed {
    logic wake;      // apply broadcasts and commit
    logic enqueue;   // write a new entry at the tail
    logic flush;     // drop all entries
    logic select;    // issue oldest ready entry
    logic retire;    // pop one idle entry from the head
    logic capture;   // latch result registers
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic head_idle; // count nonzero and head entry not busy
  } sts_t;

endpackage

>>> sv/lsqws_datapath.sv
// Entry storage, wakeup, oldest-ready selection and head retirement.
module lsqws_datapath #(
  parameter int unsigned QUEUE_DEPTH = lsqws_pkg::QueueDepth,
  parameter int unsigned ROB_TAGS    = lsqws_pkg::RobTags
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsqws_pkg::cmd_t            cmd_i,
  output lsqws_pkg::sts_t            sts_o,
  input  logic [lsqws_pkg::TagW-1:0] tag_a_i,
  input  logic [31:0]                value_a_i,
  input  logic                       valid_a_i,
  input  logic [lsqws_pkg::TagW-1:0] tag_b_i,
  input  logic [31:0]                value_b_i,
  input  logic                       valid_b_i,
  input  logic [lsqws_pkg::TagW-1:0] tag_c_i,
  input  logic                       valid_c_i,
  input  logic [7:0]                 access_code_i,
  input  logic signed [11:0]         offset_i,
  input  logic                       memory_ready_i,
  output logic                       issue_valid_o,
  output logic [31:0]                issue_address_o,
  output logic [31:0]                issue_data_o,
  output logic [lsqws_pkg::TagW-1:0] issue_tag_o,
  output logic [7:0]                 issue_access_o
);
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RtW  = (ROB_TAGS > 1) ? $clog2(ROB_TAGS) : 1;

  logic [31:0]     base_q [QUEUE_DEPTH];
  logic [31:0]     data_q [QUEUE_DEPTH];
  logic [RtW-1:0]  btag_q [QUEUE_DEPTH];
  logic [RtW-1:0]  dtag_q [QUEUE_DEPTH];
  logic [RtW-1:0]  rtag_q [QUEUE_DEPTH];
  logic [7:0]      acc_q  [QUEUE_DEPTH];
  logic [11:0]     off_q  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] busy_q, bpend_q, dpend_q, wcom_q;
  logic [IdxW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q;

  // Tags reduced modulo ROB_TAGS through a constant table over every tag value.
  function automatic logic [RtW-1:0] red(input logic [lsqws_pkg::TagW-1:0] t);
    logic [RtW-1:0] r;
    r = '0;
    for (int unsigned v = 0; v < 2**lsqws_pkg::TagW; v++) begin
      if (t == lsqws_pkg::TagW'(v)) r = RtW'(v % ROB_TAGS);
    end
    return r;
  endfunction

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] p);
    return (32'(p) + 32'd1 >= QUEUE_DEPTH) ? '0 : IdxW'(32'(p) + 32'd1);
  endfunction

  logic [RtW-1:0] ta, tb, tc;
  assign ta = red(tag_a_i);
  assign tb = red(tag_b_i);
  assign tc = red(tag_c_i);

  // Operands and flags as they stand after this cycle's broadcasts and commit.
  logic [31:0]            base_w [QUEUE_DEPTH];
  logic [31:0]            data_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] bpend_w, dpend_w, wcom_w;
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      base_w[i]  = base_q[i];
      data_w[i]  = data_q[i];
      bpend_w[i] = bpend_q[i];
      dpend_w[i] = dpend_q[i];
      wcom_w[i]  = wcom_q[i];
      if (cmd_i.wake && busy_q[i]) begin
        if (bpend_q[i]) begin
          if (valid_a_i && btag_q[i] == ta) begin
            bpend_w[i] = 1'b0; base_w[i] = value_a_i;
          end else if (valid_b_i && btag_q[i] == tb) begin
            bpend_w[i] = 1'b0; base_w[i] = value_b_i;
          end
        end
        if (dpend_q[i]) begin
          if (valid_a_i && dtag_q[i] == ta) begin
            dpend_w[i] = 1'b0; data_w[i] = value_a_i;
          end else if (valid_b_i && dtag_q[i] == tb) begin
            dpend_w[i] = 1'b0; data_w[i] = value_b_i;
          end
        end
        if (valid_c_i && wcom_q[i] && rtag_q[i] == tc) wcom_w[i] = 1'b0;
      end
    end
  end

  // Selection: oldest-first priority over rotated ready/blocking vectors.
  logic [QUEUE_DEPTH-1:0] rdy, blk;
  logic                   sel_found;
  logic [IdxW-1:0]        sel_idx;
  always_comb begin
    logic stop;
    logic [IdxW-1:0] idx;
    sel_found = 1'b0;
    sel_idx   = '0;
    stop      = 1'b0;
    idx       = head_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rdy[i] = busy_q[i] & ~bpend_w[i] & ~dpend_w[i] & ~wcom_w[i];
      blk[i] = busy_q[i] & acc_q[i][7] & ~acc_q[i][6];
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (!stop && CntW'(k) < count_q) begin
        if (rdy[idx]) begin
          sel_found = 1'b1;
          sel_idx   = idx;
          stop      = 1'b1;
        end else if (blk[idx]) begin
          stop = 1'b1;
        end
      end
      idx = nxt(idx);
    end
  end

  logic do_issue;
  assign do_issue = cmd_i.select & memory_ready_i & sel_found;

  assign sts_o.full      = (count_q == CntW'(QUEUE_DEPTH));
  assign sts_o.head_idle = (count_q != '0) & ~busy_q[head_q];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      issue_valid_o <= 1'b0;
    end else begin
      if (cmd_i.capture) issue_valid_o <= do_issue;
      if (cmd_i.flush) begin
        busy_q  <= '0;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.enqueue) begin
        busy_q[tail_q] <= 1'b1;
        tail_q  <= nxt(tail_q);
        count_q <= count_q + 1'b1;
      end else if (cmd_i.retire) begin
        head_q  <= nxt(head_q);
        count_q <= count_q - 1'b1;
      end else if (do_issue) begin
        busy_q[sel_idx] <= 1'b0;
      end
    end
  end

  // Entry payload and pending flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue) begin
      base_q[tail_q]  <= value_a_i;
      data_q[tail_q]  <= value_b_i;
      btag_q[tail_q]  <= ta;
      dtag_q[tail_q]  <= tb;
      rtag_q[tail_q]  <= tc;
      bpend_q[tail_q] <= valid_a_i;
      dpend_q[tail_q] <= valid_b_i;
      wcom_q[tail_q]  <= valid_c_i;
      acc_q[tail_q]   <= access_code_i;
      off_q[tail_q]   <= offset_i;
    end else if (cmd_i.wake) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        base_q[i]  <= base_w[i];
        data_q[i]  <= data_w[i];
        bpend_q[i] <= bpend_w[i];
        dpend_q[i] <= dpend_w[i];
        wcom_q[i]  <= wcom_w[i];
      end
    end
  end

  // Result registers; zero when nothing issues.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (do_issue) begin
        issue_address_o <= base_w[sel_idx] + {{20{off_q[sel_idx][11]}}, off_q[sel_idx]};
        issue_data_o    <= data_w[sel_idx];
        issue_tag_o     <= lsqws_pkg::TagW'(rtag_q[sel_idx]);
        issue_access_o  <= acc_q[sel_idx];
      end else begin
        issue_address_o <= '0;
        issue_data_o    <= '0;
        issue_tag_o     <= '0;
        issue_access_o  <= '0;
      end
    end
  end
endmodule

>>> sv/lsqws_ctrl.sv
// Sequencer: decode the item, wake and select, retire idle head entries, deliver result.
module lsqws_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsqws_pkg::cmd_t cmd_o,
  input  lsqws_pkg::sts_t sts_i,
  output logic            queue_full_o,
  output logic            enqueue_rejected_o
);
  typedef enum logic [1:0] {StIdle, StRetire, StOut} state_e;
  state_e state_q;
  logic   acc;

  // Take a new item when idle, or when the held result leaves this cycle.
  assign in_ready_o = (state_q == StIdle) || (state_q == StOut && out_ready_i);
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o = '0;
    if (acc) begin
      cmd_o.capture = 1'b1;
      case (kind_i)
        lsqws_pkg::KindCycle: begin
          cmd_o.wake   = 1'b1;
          cmd_o.select = 1'b1;
        end
        lsqws_pkg::KindEnqueue: cmd_o.enqueue = ~sts_i.full;
        lsqws_pkg::KindFlush:   cmd_o.flush   = 1'b1;
        default: ;
      endcase
    end else if (state_q == StRetire) begin
      cmd_o.retire = sts_i.head_idle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      out_valid_o        <= 1'b0;
      enqueue_rejected_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle, StOut: begin
          if (state_q == StOut && out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= StIdle;
          end
          if (acc) begin
            enqueue_rejected_o <= (kind_i == lsqws_pkg::KindEnqueue) & sts_i.full;
            out_valid_o        <= 1'b0;
            if (kind_i == lsqws_pkg::KindCycle) begin
              state_q <= StRetire;
            end else begin
              state_q     <= StOut;
              out_valid_o <= 1'b1;
            end
          end
        end
        StRetire: begin
          if (!sts_i.head_idle) begin
            state_q     <= StOut;
            out_valid_o <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Full flag is read once the result is presented, after retirement settled.
  assign queue_full_o = sts_i.full;
endmodule

>>> sv/load_store_queue_wakeup_select.sv
// Top level of the load/store wakeup-select buffer.
// Circular load/store buffer with operand wakeup and oldest-ready issue. Any
// transaction other than a cycle yields its result in the cycle after it is
// accepted. A cycle transaction applies both broadcasts and the commit, picks
// the oldest ready entry in the woken state (stopping at a busy, non-hang
// store that is not ready), then pops idle entries from the head one at a
// time, retiring at most QUEUE_DEPTH, until it sees that the head is settled,
// and only then presents its result. The result sits in an output register;
// the next transaction is taken in the same cycle that result is consumed.
// Tags are reduced modulo ROB_TAGS.
module load_store_queue_wakeup_select #(
  parameter int unsigned QUEUE_DEPTH = lsqws_pkg::QueueDepth,
  parameter int unsigned ROB_TAGS    = lsqws_pkg::RobTags
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [lsqws_pkg::TagW-1:0] tag_a_i,
  input  logic [31:0]                value_a_i,
  input  logic                       valid_a_i,
  input  logic [lsqws_pkg::TagW-1:0] tag_b_i,
  input  logic [31:0]                value_b_i,
  input  logic                       valid_b_i,
  input  logic [lsqws_pkg::TagW-1:0] tag_c_i,
  input  logic                       valid_c_i,
  input  logic [7:0]                 access_code_i,
  input  logic signed [11:0]         offset_i,
  input  logic                       memory_ready_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       issue_valid_o,
  output logic [31:0]                issue_address_o,
  output logic [31:0]                issue_data_o,
  output logic [lsqws_pkg::TagW-1:0] issue_tag_o,
  output logic [7:0]                 issue_access_o,
  output logic                       queue_full_o,
  output logic                       enqueue_rejected_o
);
  lsqws_pkg::cmd_t cmd;
  lsqws_pkg::sts_t sts;

  // Sequence each transaction.
  lsqws_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts), .queue_full_o, .enqueue_rejected_o
  );

  // Hold entries, wake, select and retire.
  lsqws_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ROB_TAGS(ROB_TAGS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .tag_a_i, .value_a_i, .valid_a_i, .tag_b_i, .value_b_i, .valid_b_i,
    .tag_c_i, .valid_c_i, .access_code_i, .offset_i, .memory_ready_i,
    .issue_valid_o, .issue_address_o, .issue_data_o, .issue_tag_o, .issue_access_o
  );
endmodule
